// ----- design/dpcm_pkg.sv -----
// Shared types and constants of the pattern category matcher.
package dpcm_pkg;

    localparam int DEF_NUM_PATTERNS    = 256;
    localparam int DEF_MAX_PATTERN_LEN = 32;

    // item kinds carried by req_type
    localparam logic [1:0] REQ_SCAN  = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // verdict codes
    localparam logic [2:0] CAT_ALLOW = 3'd0;
    localparam logic [2:0] CAT_MIN   = 3'd1;
    localparam logic [2:0] CAT_MAX   = 3'd5;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    // write controls that the sequencer hands to every cell
    typedef struct packed {
        logic pat_we;    // load item: store byte where position matches
        logic pm_clr;    // load or clear item: zero the slot's match bit
        logic sweep_we;  // scan write-back of the new match bit
        logic keep;      // slot valid and string continues
    } t_cell_ctl;

endpackage

// ----- design/domain_pattern_category_matcher.sv -----
// Top level: slot sequencer, slot info store and the row of position cells.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+----------------------------------------
//  in      | i_in_valid  | o_in_ready  | i_req_type .. i_request_end
//  out     | o_out_valid | i_out_ready | o_verdict
//
// Load and clear items are taken in idle without leaving it. A scan item sweeps
// the slots one per cycle through the shared RAM read port of each cell, then
// drains the last write-back and returns to idle; with request_end it moves the
// verdict into the output register first, waiting while that is still full.
// After reset a clearing pass over all slots zeroes the slot valid flags;
// no item is accepted meanwhile. A stalled output only holds the block when a
// new verdict must be written.
module domain_pattern_category_matcher
    import dpcm_pkg::*;
#(
    parameter int NUM_PATTERNS    = DEF_NUM_PATTERNS,
    parameter int MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_char_byte,
    input  logic [7:0] i_slot_index,
    input  logic [4:0] i_byte_position,
    input  logic [5:0] i_pattern_length,
    input  logic [2:0] i_category,
    input  logic       i_string_end,
    input  logic       i_request_end,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_verdict
);

    localparam int SLOT_W = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
    localparam int LEN_W  = $clog2(MAX_PATTERN_LEN);
    localparam int INFO_W = 1 + 6 + 3;

    t_state r_state, n_state;

    logic [SLOT_W-1:0] r_rd_slot, n_rd_slot;
    logic [SLOT_W-1:0] r_wr_slot;
    logic              r_pipe_v;
    logic [7:0]        r_char;
    logic              r_s_end;
    logic              r_r_end;
    logic [2:0]        r_best, n_best;
    logic              r_out_v, n_out_v;
    logic [2:0]        r_out_verdict;

    logic              w_in_acc;
    logic              w_last_slot;
    logic              w_emit;
    logic [31:0]       w_slot_ext;
    logic              w_slot_ok;
    logic              w_is_scan;
    logic              w_is_load;
    logic              w_is_clear;

    logic              w_info_we;
    logic [SLOT_W-1:0] w_info_wr_addr;
    logic [INFO_W-1:0] w_info_wr_data;
    logic [INFO_W-1:0] w_info_rd;
    logic              w_info_valid;
    logic [5:0]        w_info_len;
    logic [2:0]        w_info_cat;
    logic [31:0]       w_len_m1;
    logic              w_len_ok;
    logic              w_hit;
    logic              w_cat_wins;

    t_cell_ctl         w_ctl;
    logic [SLOT_W-1:0] w_cell_wr_addr;
    logic [MAX_PATTERN_LEN-1:0] w_old_vec;
    logic [MAX_PATTERN_LEN-1:0] w_new_vec;

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_last_slot = (r_rd_slot == SLOT_W'(NUM_PATTERNS - 1));
    assign w_slot_ext  = 32'(i_slot_index);
    assign w_slot_ok   = (w_slot_ext < NUM_PATTERNS);
    assign w_is_scan   = (i_req_type == REQ_SCAN);
    assign w_is_load   = (i_req_type == REQ_LOAD);
    assign w_is_clear  = (i_req_type == REQ_CLEAR);
    assign w_emit      = (r_state == ST_EMIT) && (!r_out_v || i_out_ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (w_last_slot) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_acc && w_is_scan) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (w_last_slot) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = r_r_end ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (w_emit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_ready = 1'b0;
        n_rd_slot  = r_rd_slot;
        unique case (r_state)
            ST_INIT: begin
                n_rd_slot = r_rd_slot + 1'b1;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (w_in_acc && w_is_scan) begin
                    n_rd_slot = '0;
                end
            end
            ST_SWEEP: begin
                n_rd_slot = r_rd_slot + 1'b1;
            end
            ST_DRAIN, ST_EMIT: begin
                n_rd_slot = r_rd_slot;
            end
            default: begin
                n_rd_slot = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_rd_slot <= '0;
            r_pipe_v  <= 1'b0;
            r_best    <= CAT_ALLOW;
            r_out_v   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_slot <= n_rd_slot;
            r_pipe_v  <= (r_state == ST_SWEEP);
            r_best    <= n_best;
            r_out_v   <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_slot <= r_rd_slot;
        if (w_in_acc && w_is_scan) begin
            r_char  <= i_char_byte;
            r_s_end <= i_string_end || i_request_end;
            r_r_end <= i_request_end;
        end
        if (w_emit) begin
            r_out_verdict <= r_best;
        end
    end

    // slot info: valid, length, category
    always_comb begin
        w_info_we      = 1'b0;
        w_info_wr_addr = w_slot_ext[SLOT_W-1:0];
        w_info_wr_data = {w_is_load, i_pattern_length, i_category};
        if (r_state == ST_INIT) begin
            w_info_we      = 1'b1;
            w_info_wr_addr = r_rd_slot;
            w_info_wr_data = '0;
        end else if (w_in_acc && w_slot_ok && (w_is_load || w_is_clear)) begin
            w_info_we = 1'b1;
        end
    end

    dpcm_ram #(
        .WIDTH (INFO_W),
        .DEPTH (NUM_PATTERNS)
    ) u_info_ram (
        .i_clk     (i_clk),
        .i_we      (w_info_we),
        .i_wr_addr (w_info_wr_addr),
        .i_wr_data (w_info_wr_data),
        .i_rd_addr (r_rd_slot),
        .o_rd_data (w_info_rd)
    );

    assign w_info_valid = w_info_rd[INFO_W-1];
    assign w_info_len   = w_info_rd[8:3];
    assign w_info_cat   = w_info_rd[2:0];

    // hit check on the slot being written back
    assign w_len_m1   = 32'(w_info_len) - 32'd1;
    assign w_len_ok   = (w_info_len != 6'd0) && (32'(w_info_len) <= MAX_PATTERN_LEN);
    assign w_hit      = r_pipe_v && w_info_valid && w_len_ok
                        && w_new_vec[w_len_m1[LEN_W-1:0]];
    assign w_cat_wins = (w_info_cat >= CAT_MIN) && (w_info_cat <= CAT_MAX)
                        && ((r_best == CAT_ALLOW) || (w_info_cat < r_best));

    always_comb begin
        n_best = r_best;
        if (w_emit) begin
            n_best = CAT_ALLOW;
        end else if (w_hit && w_cat_wins) begin
            n_best = w_info_cat;
        end
    end

    always_comb begin
        n_out_v = r_out_v;
        if (w_emit) begin
            n_out_v = 1'b1;
        end else if (i_out_ready) begin
            n_out_v = 1'b0;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_verdict   = r_out_verdict;

    // cell controls
    always_comb begin
        w_ctl.pat_we   = w_in_acc && w_slot_ok && w_is_load;
        w_ctl.pm_clr   = w_in_acc && w_slot_ok && (w_is_load || w_is_clear);
        w_ctl.sweep_we = r_pipe_v;
        w_ctl.keep     = w_info_valid && !r_s_end;
        w_cell_wr_addr = r_pipe_v ? r_wr_slot : w_slot_ext[SLOT_W-1:0];
    end

    for (genvar k = 0; k < MAX_PATTERN_LEN; k++) begin : g_cell
        logic w_chain_in;
        if (k == 0) begin : g_head
            assign w_chain_in = 1'b1;
        end else begin : g_body
            assign w_chain_in = w_old_vec[k-1];
        end

        dpcm_cell #(
            .IDX          (k),
            .NUM_PATTERNS (NUM_PATTERNS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_wr_addr  (w_cell_wr_addr),
            .i_rd_addr  (r_rd_slot),
            .i_pos      (i_byte_position),
            .i_wr_byte  (i_char_byte),
            .i_cmp_byte (r_char),
            .i_chain    (w_chain_in),
            .o_chain    (w_old_vec[k]),
            .o_new_bit  (w_new_vec[k])
        );
    end

endmodule

// ----- design/dpcm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dpcm_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/dpcm_cell.sv -----
// One pattern position: byte column and match-bit column for all slots.
module dpcm_cell
    import dpcm_pkg::*;
#(
    parameter  int IDX          = 0,
    parameter  int NUM_PATTERNS = DEF_NUM_PATTERNS,
    localparam int SLOT_W       = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1
) (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [SLOT_W-1:0] i_wr_addr,
    input  logic [SLOT_W-1:0] i_rd_addr,
    input  logic [4:0]        i_pos,
    input  logic [7:0]        i_wr_byte,
    input  logic [7:0]        i_cmp_byte,
    input  logic              i_chain,     // previous match bit of left neighbor
    output logic              o_chain,     // previous match bit of this cell
    output logic              o_new_bit
);

    logic [7:0] w_pat_byte;
    logic       w_old_bit;
    logic       w_pat_we;
    logic       w_pm_we;
    logic       w_pm_data;

    assign w_pat_we  = i_ctl.pat_we && (32'(i_pos) == IDX);
    assign o_new_bit = i_chain && (w_pat_byte == i_cmp_byte);
    assign w_pm_we   = i_ctl.pm_clr || i_ctl.sweep_we;
    assign w_pm_data = i_ctl.sweep_we && i_ctl.keep && o_new_bit;
    assign o_chain   = w_old_bit;

    dpcm_ram #(
        .WIDTH (8),
        .DEPTH (NUM_PATTERNS)
    ) u_pat_ram (
        .i_clk     (i_clk),
        .i_we      (w_pat_we),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_byte),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (w_pat_byte)
    );

    dpcm_ram #(
        .WIDTH (1),
        .DEPTH (NUM_PATTERNS)
    ) u_pm_ram (
        .i_clk     (i_clk),
        .i_we      (w_pm_we),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (w_pm_data),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (w_old_bit)
    );

endmodule
